@@ sv/text_encoding_detector_unit_macros.svh @@
// Assertion macros for the text encoding detector.
`ifndef TEXT_ENCODING_DETECTOR_UNIT_MACROS_SVH
`define TEXT_ENCODING_DETECTOR_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define TED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TED_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TED_ASSERT(lbl, prop, msg)
`define TED_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ sv/ted_pkg.sv @@
package ted_pkg;

  typedef enum logic [3:0] {
    ENC_UNKNOWN = 4'd0,
    ENC_UTF8    = 4'd1,
    ENC_WIN1252 = 4'd2,
    ENC_UTF16LE = 4'd3,
    ENC_UTF16BE = 4'd4,
    ENC_UTF32LE = 4'd5,
    ENC_UTF32BE = 4'd6,
    ENC_UTF7    = 4'd7,
    ENC_UTF1    = 4'd8,
    ENC_EBCDIC  = 4'd9,
    ENC_SCSU    = 4'd10,
    ENC_BOCU1   = 4'd11,
    ENC_GB18030 = 4'd12
  } enc_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0] encoding_code;
    logic [2:0] mark_length;
  } out_item_t;

  // Scan state after the current byte has been folded in.
  typedef struct packed {
    logic [31:0] head_bytes;
    logic [2:0]  head_count;
    logic [1:0]  byte_phase;
    logic [3:0]  quad_and;
    logic [3:0]  quad_or;
    logic [1:0]  pair_and;
    logic [1:0]  pair_or;
  } scan_post_t;

  localparam logic [2:0] HEAD_FULL = 3'd4;

  function automatic enc_t quad_code(input logic [3:0] m);
    enc_t c;
    case (m) inside
      4'h1, 4'h2, 4'h3: c = ENC_UTF32LE;
      4'h4, 4'h8, 4'hC: c = ENC_UTF32BE;
      4'h5:             c = ENC_UTF16LE;
      4'hA:             c = ENC_UTF16BE;
      4'hF:             c = ENC_UTF8;
      default:          c = ENC_UNKNOWN;
    endcase
    return c;
  endfunction

  function automatic enc_t pair_code(input logic [1:0] m);
    enc_t c;
    case (m)
      2'h1:    c = ENC_UTF16LE;
      2'h2:    c = ENC_UTF16BE;
      2'h3:    c = ENC_UTF8;
      default: c = ENC_UNKNOWN;
    endcase
    return c;
  endfunction

  // Byte order mark lookup in priority order. The four-byte UTF-32LE mark
  // starts with the UTF-16LE mark, so it never wins and is not listed.
  function automatic out_item_t mark_lookup(input logic [31:0] h, input logic [2:0] n);
    out_item_t r;
    logic [7:0] b0, b1, b2, b3;
    logic has2, has3, has4;
    b0 = h[7:0];
    b1 = h[15:8];
    b2 = h[23:16];
    b3 = h[31:24];
    has2 = n >= 3'd2;
    has3 = n >= 3'd3;
    has4 = n >= HEAD_FULL;
    r.encoding_code = ENC_UNKNOWN;
    r.mark_length   = 3'd0;
    if (has3 && b0 == 8'hEF && b1 == 8'hBB && b2 == 8'hBF) begin
      r = '{ENC_UTF8, 3'd3};
    end else if (has2 && b0 == 8'hFE && b1 == 8'hFF) begin
      r = '{ENC_UTF16BE, 3'd2};
    end else if (has2 && b0 == 8'hFF && b1 == 8'hFE) begin
      r = '{ENC_UTF16LE, 3'd2};
    end else if (has4 && b0 == 8'h00 && b1 == 8'h00 && b2 == 8'hFE && b3 == 8'hFF) begin
      r = '{ENC_UTF32BE, 3'd4};
    end else if (has4 && b0 == 8'h2B && b1 == 8'h2F && b2 == 8'h76 &&
                 (b3 == 8'h38 || b3 == 8'h39 || b3 == 8'h2B || b3 == 8'h2F)) begin
      r = '{ENC_UTF7, 3'd3};
    end else if (has3 && b0 == 8'hF7 && b1 == 8'h64 && b2 == 8'h4C) begin
      r = '{ENC_UTF1, 3'd3};
    end else if (has4 && b0 == 8'hDD && b1 == 8'h73 && b2 == 8'h66 && b3 == 8'h73) begin
      r = '{ENC_EBCDIC, 3'd4};
    end else if (has3 && b0 == 8'h0E && b1 == 8'hFE && b2 == 8'hFF) begin
      r = '{ENC_SCSU, 3'd3};
    end else if (has3 && b0 == 8'hFB && b1 == 8'hEE && b2 == 8'h28) begin
      r = '{ENC_BOCU1, 3'd3};
    end else if (has4 && b0 == 8'h84 && b1 == 8'h31 && b2 == 8'h95 && b3 == 8'h33) begin
      r = '{ENC_GB18030, 3'd4};
    end
    return r;
  endfunction

endpackage

@@ sv/ted_scan.sv @@
module ted_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ted_pkg::in_item_t   item,
  output ted_pkg::scan_post_t post
);
  import ted_pkg::*;

  logic [31:0] head_r, head_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  marks_r, marks_nxt;
  logic [3:0]  qand_r, qand_nxt, qor_r, qor_nxt;
  logic [1:0]  pand_r, pand_nxt, por_r, por_nxt;
  logic        nz;
  logic [1:0]  pbits;
  logic [3:0]  qbits;

  assign nz = item.data_byte != 8'd0;

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (count_r < HEAD_FULL) begin
      for (int i = 0; i < 4; i++) begin
        if (count_r[1:0] == 2'(i)) head_nxt[8*i +: 8] = item.data_byte;
      end
      count_nxt = count_r + 3'd1;
    end

    pbits    = {nz, (phase_r == 2'd3) ? marks_r[2] : marks_r[0]};
    qbits    = {nz, marks_r};
    pand_nxt = pand_r;
    por_nxt  = por_r;
    qand_nxt = qand_r;
    qor_nxt  = qor_r;
    marks_nxt = marks_r;
    if (phase_r[0]) begin
      pand_nxt = pand_r & pbits;
      por_nxt  = por_r | pbits;
    end
    if (phase_r == 2'd3) begin
      qand_nxt  = qand_r & qbits;
      qor_nxt   = qor_r | qbits;
      marks_nxt = 3'd0;
    end else begin
      marks_nxt[phase_r] = marks_r[phase_r] | nz;
    end
    phase_nxt = phase_r + 2'd1;
  end

  assign post = '{head_nxt, count_nxt, phase_nxt, qand_nxt, qor_nxt, pand_nxt, por_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      head_r  <= '0;
      count_r <= '0;
      phase_r <= '0;
      marks_r <= '0;
      qand_r  <= '1;
      qor_r   <= '0;
      pand_r  <= '1;
      por_r   <= '0;
    end else if (step) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      phase_r <= phase_nxt;
      marks_r <= marks_nxt;
      qand_r  <= qand_nxt;
      qor_r   <= qor_nxt;
      pand_r  <= pand_nxt;
      por_r   <= por_nxt;
    end
  end

endmodule

@@ sv/ted_utf8.sv @@
module ted_utf8 (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  ted_pkg::in_item_t item,
  output logic              error_post
);
  import ted_pkg::*;

  // Allowed range of the next continuation byte.
  localparam logic [2:0] RNG_ANY  = 3'd0;  // 80-BF
  localparam logic [2:0] RNG_A0   = 3'd1;  // A0-BF
  localparam logic [2:0] RNG_9F   = 3'd2;  // 80-9F
  localparam logic [2:0] RNG_90   = 3'd3;  // 90-BF
  localparam logic [2:0] RNG_8F   = 3'd4;  // 80-8F

  logic [1:0] pend_r, pend_nxt;
  logic [2:0] rng_r, rng_nxt;
  logic       err_r, err_nxt;
  logic [7:0] b, lo, hi;

  assign b = item.data_byte;

  always_comb begin
    pend_nxt = pend_r;
    rng_nxt  = rng_r;
    err_nxt  = err_r;
    lo = 8'h80;
    hi = 8'hBF;
    case (rng_r)
      RNG_A0:  lo = 8'hA0;
      RNG_9F:  hi = 8'h9F;
      RNG_90:  lo = 8'h90;
      RNG_8F:  hi = 8'h8F;
      default: ;
    endcase
    if (pend_r != 2'd0) begin
      if (b < lo || b > hi) begin
        err_nxt  = 1'b1;
        pend_nxt = 2'd0;
      end else begin
        pend_nxt = pend_r - 2'd1;
      end
      rng_nxt = RNG_ANY;
    end else if (b >= 8'h80) begin
      if (b >= 8'hC2 && b <= 8'hDF) begin
        pend_nxt = 2'd1; rng_nxt = RNG_ANY;
      end else if (b == 8'hE0) begin
        pend_nxt = 2'd2; rng_nxt = RNG_A0;
      end else if (b == 8'hED) begin
        pend_nxt = 2'd2; rng_nxt = RNG_9F;
      end else if (b >= 8'hE1 && b <= 8'hEF) begin
        pend_nxt = 2'd2; rng_nxt = RNG_ANY;
      end else if (b == 8'hF0) begin
        pend_nxt = 2'd3; rng_nxt = RNG_90;
      end else if (b == 8'hF4) begin
        pend_nxt = 2'd3; rng_nxt = RNG_8F;
      end else if (b >= 8'hF1 && b <= 8'hF3) begin
        pend_nxt = 2'd3; rng_nxt = RNG_ANY;
      end else begin
        err_nxt = 1'b1;
      end
    end
  end

  assign error_post = err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      pend_r <= '0;
      rng_r  <= RNG_ANY;
      err_r  <= 1'b0;
    end else if (step) begin
      pend_r <= pend_nxt;
      rng_r  <= rng_nxt;
      err_r  <= err_nxt;
    end
  end

endmodule

@@ sv/ted_verdict.sv @@
module ted_verdict (
  input  ted_pkg::scan_post_t post,
  input  logic                utf8_error,
  output ted_pkg::out_item_t  verdict
);
  import ted_pkg::*;

  out_item_t mark;
  enc_t      c_and, c_or;

  assign mark = mark_lookup(post.head_bytes, post.head_count);

  always_comb begin
    case (post.byte_phase)
      2'd0: begin
        c_and = quad_code(post.quad_and);
        c_or  = quad_code(post.quad_or);
      end
      2'd2: begin
        c_and = pair_code(post.pair_and);
        c_or  = pair_code(post.pair_or);
      end
      default: begin
        c_and = ENC_UTF8;
        c_or  = ENC_UTF8;
      end
    endcase

    if (mark.encoding_code != ENC_UNKNOWN) begin
      verdict = mark;
    end else begin
      verdict.mark_length = 3'd0;
      if (c_and != c_or) begin
        verdict.encoding_code = ENC_UNKNOWN;
      end else if (c_and != ENC_UTF8) begin
        verdict.encoding_code = c_and;
      end else begin
        verdict.encoding_code = utf8_error ? ENC_WIN1252 : ENC_UTF8;
      end
    end
  end

endmodule

@@ sv/text_encoding_detector_unit.sv @@
// Text encoding detector: one byte of a buffer per input transfer, one
// verdict per buffer.
// Input channel: in_valid / in_stall / in_data (data_byte, last_byte).
//   A byte with last_byte set closes the buffer.
// Result channel: out_valid / out_stall / out_data (encoding_code,
//   mark_length). One result follows each byte flagged last; other bytes
//   give none.
// Throughput: one byte per cycle, but a last byte waits while the result
//   register is full. Each byte is held in the input register; the mask, mark
//   and UTF-8 logic then folds it into the state and, for a last byte, loads
//   the result register.
// Reset clears both pipeline registers and all scan state; the block is
//   ready as soon as reset ends. After each verdict the scan
//   state returns to its reset values, so buffers follow back to back.
// When the receiver stalls, the result register holds its verdict. Bytes
//   that are not last keep flowing; a last byte waits in the input register
//   until the result register frees, and in_stall rises meanwhile.
module text_encoding_detector_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ted_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ted_pkg::out_item_t out_data
);
  import ted_pkg::*;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       out_free;
  logic       s1_adv;
  logic       verdict_load;
  scan_post_t post;
  logic       utf8_err;
  out_item_t  verdict;

  assign out_free     = !out_valid_r || !out_stall;
  assign s1_adv       = s1_valid_r && (!s1_item_r.last_byte || out_free);
  assign verdict_load = s1_adv && s1_item_r.last_byte;
  assign in_stall     = s1_valid_r && !s1_adv;

  ted_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_item_r),
    .post  (post)
  );

  ted_utf8 u_utf8 (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_adv),
    .item       (s1_item_r),
    .error_post (utf8_err)
  );

  ted_verdict u_verdict (
    .post       (post),
    .utf8_error (utf8_err),
    .verdict    (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) s1_valid_r <= in_valid;
      if (verdict_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) s1_item_r <= in_data;
    if (verdict_load) out_item_r <= verdict;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`include "text_encoding_detector_unit_macros.svh"

  `TED_ASSERT(a_stall_needs_item, in_stall |-> s1_valid_r, "input stalled with empty stage")
  `TED_ASSERT(a_verdict_lands, verdict_load |=> out_valid_r, "verdict not registered")
  `TED_ASSERT(a_result_from_last, $rose(out_valid_r) |-> $past(verdict_load), "stray result")
  `TED_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid_r && !s1_valid_r, "pipeline not cleared by reset")

endmodule

@@ verif/tb_text_encoding_detector_unit.sv @@
module tb_text_encoding_detector_unit;
  import ted_pkg::*;

  // allowed range of the next UTF-8 continuation byte
  localparam int unsigned RNG_ANY = 0;  // 80-BF
  localparam int unsigned RNG_A0  = 1;  // A0-BF
  localparam int unsigned RNG_9F  = 2;  // 80-9F
  localparam int unsigned RNG_90  = 3;  // 90-BF
  localparam int unsigned RNG_8F  = 4;  // 80-8F

  localparam int unsigned NUM_MARKS    = 11;
  localparam int unsigned RANDOM_BYTES = 1050;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 6;

  class verdict_board;
    logic [31:0] mark_word [NUM_MARKS];
    int unsigned mark_len  [NUM_MARKS];
    enc_t        mark_enc  [NUM_MARKS];

    logic [31:0] head;
    int unsigned head_n;
    int unsigned phase;
    logic [2:0]  grp;
    logic [3:0]  q_and, q_or;
    logic [1:0]  p_and, p_or;
    int unsigned u8_left;
    int unsigned u8_range;
    bit          u8_bad;

    out_item_t   verdicts [$];
    int unsigned errors;

    function new();
      // byte i of a mark sits in bits 8i..8i+7, table order is priority order
      mark_word = '{32'h00BFBBEF, 32'h0000FFFE, 32'h0000FEFF, 32'hFFFE0000, 32'h0000FEFF,
                    32'h00762F2B, 32'h004C64F7, 32'h736673DD, 32'h00FFFE0E, 32'h0028EEFB,
                    32'h33953184};
      mark_len  = '{3, 2, 2, 4, 4, 3, 3, 4, 3, 3, 4};
      mark_enc  = '{ENC_UTF8, ENC_UTF16BE, ENC_UTF16LE, ENC_UTF32BE, ENC_UTF32LE, ENC_UTF7,
                    ENC_UTF1, ENC_EBCDIC, ENC_SCSU, ENC_BOCU1, ENC_GB18030};
      errors = 0;
      clear();
    endfunction

    function void clear();
      head     = '0;
      head_n   = 0;
      phase    = 0;
      grp      = '0;
      q_and    = 4'hF;
      q_or     = 4'h0;
      p_and    = 2'h3;
      p_or     = 2'h0;
      u8_left  = 0;
      u8_range = RNG_ANY;
      u8_bad   = 1'b0;
    endfunction

    function enc_t from_quad(logic [3:0] m);
      case (m)
        4'h1, 4'h2, 4'h3: return ENC_UTF32LE;
        4'h4, 4'h8, 4'hC: return ENC_UTF32BE;
        4'h5:             return ENC_UTF16LE;
        4'hA:             return ENC_UTF16BE;
        4'hF:             return ENC_UTF8;
        default:          return ENC_UNKNOWN;
      endcase
    endfunction

    function enc_t from_pair(logic [1:0] m);
      case (m)
        2'h1:    return ENC_UTF16LE;
        2'h2:    return ENC_UTF16BE;
        2'h3:    return ENC_UTF8;
        default: return ENC_UNKNOWN;
      endcase
    endfunction

    function void feed_utf8(logic [7:0] b);
      logic [7:0] lo, hi;
      if (u8_left > 0) begin
        lo = 8'h80;
        hi = 8'hBF;
        case (u8_range)
          RNG_A0:  lo = 8'hA0;
          RNG_9F:  hi = 8'h9F;
          RNG_90:  lo = 8'h90;
          RNG_8F:  hi = 8'h8F;
          default: ;
        endcase
        if (b < lo || b > hi) begin
          u8_bad  = 1'b1;
          u8_left = 0;
        end else begin
          u8_left--;
        end
        u8_range = RNG_ANY;
      end else if (b >= 8'h80) begin
        if (b >= 8'hC2 && b <= 8'hDF) begin
          u8_left = 1; u8_range = RNG_ANY;
        end else if (b == 8'hE0) begin
          u8_left = 2; u8_range = RNG_A0;
        end else if (b == 8'hED) begin
          u8_left = 2; u8_range = RNG_9F;
        end else if (b >= 8'hE1 && b <= 8'hEF) begin
          u8_left = 2; u8_range = RNG_ANY;
        end else if (b == 8'hF0) begin
          u8_left = 3; u8_range = RNG_90;
        end else if (b == 8'hF4) begin
          u8_left = 3; u8_range = RNG_8F;
        end else if (b >= 8'hF1 && b <= 8'hF3) begin
          u8_left = 3; u8_range = RNG_ANY;
        end else begin
          u8_bad = 1'b1;
        end
      end
    endfunction

    // Fold one accepted byte into the scan state; queue a verdict on a last byte.
    function void note_input(in_item_t it);
      logic [7:0] b;
      logic       nz;
      logic [1:0] pm;
      logic [3:0] qm;
      logic [7:0] fourth;
      enc_t       c1, c2;
      out_item_t  v;
      bit         hit, found;
      b  = it.data_byte;
      nz = (b != 8'h00);
      if (head_n < 4) begin
        head[8*head_n +: 8] = b;
        head_n++;
      end
      if (phase == 1 || phase == 3) begin
        pm = {nz, grp[phase-1]};
        p_and &= pm;
        p_or  |= pm;
      end
      if (phase == 3) begin
        qm = {nz, grp};
        q_and &= qm;
        q_or  |= qm;
        grp = '0;
      end else begin
        grp[phase] = nz;
      end
      phase = (phase + 1) % 4;
      feed_utf8(b);
      if (!it.last_byte) return;

      v.encoding_code = ENC_UNKNOWN;
      v.mark_length   = 3'd0;
      found = 1'b0;
      for (int i = 0; i < NUM_MARKS && !found; i++) begin
        hit = (head_n >= mark_len[i]);
        for (int k = 0; k < mark_len[i]; k++)
          if (head[8*k +: 8] != mark_word[i][8*k +: 8]) hit = 1'b0;
        if (hit && mark_enc[i] == ENC_UTF7) begin
          // UTF-7 also needs a fourth byte from a short list
          fourth = head[31:24];
          if (head_n < 4 || !(fourth inside {8'h38, 8'h39, 8'h2B, 8'h2F})) hit = 1'b0;
        end
        if (hit) begin
          v.encoding_code = mark_enc[i];
          v.mark_length   = 3'(mark_len[i]);
          found = 1'b1;
        end
      end
      if (!found) begin
        if (phase == 0) begin
          c1 = from_quad(q_and);
          c2 = from_quad(q_or);
        end else if (phase == 2) begin
          c1 = from_pair(p_and);
          c2 = from_pair(p_or);
        end else begin
          c1 = ENC_UTF8;
          c2 = ENC_UTF8;
        end
        if (c1 != c2)
          v.encoding_code = ENC_UNKNOWN;
        else if (c1 != ENC_UTF8)
          v.encoding_code = c1;
        else
          v.encoding_code = u8_bad ? ENC_WIN1252 : ENC_UTF8;
      end
      verdicts.push_back(v);
      clear();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (verdicts.size() == 0) begin
        $error("unexpected verdict: encoding_code %0d mark_length %0d",
               got.encoding_code, got.mark_length);
        errors++;
        return;
      end
      want = verdicts.pop_front();
      if (got.encoding_code !== want.encoding_code) begin
        $error("encoding_code: expected %0d, actual %0d", want.encoding_code, got.encoding_code);
        errors++;
      end
      if (got.mark_length !== want.mark_length) begin
        $error("mark_length: expected %0d, actual %0d", want.mark_length, got.mark_length);
        errors++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  verdict_board sb = new();
  logic [7:0]   text_bytes [$];
  int unsigned  sent_bytes;
  bit           calm;
  int unsigned  stuck_cycles;

  text_encoding_detector_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 27);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        stuck_cycles <= 0;
      else
        stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("FAIL text_encoding_detector_unit");
        $finish;
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  task automatic send_byte(input in_item_t it);
    while (!calm && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    // hold until the transfer happens
    do @(posedge clk); while (in_stall);
    sent_bytes++;
    calm = (sent_bytes >= 450 && sent_bytes < 650);
  endtask

  task automatic send_text();
    in_item_t it;
    for (int i = 0; i < text_bytes.size(); i++) begin
      it.data_byte = text_bytes[i];
      it.last_byte = (i == text_bytes.size() - 1);
      send_byte(it);
    end
  endtask

  task automatic load_word(input logic [31:0] w, input int unsigned n);
    text_bytes.delete();
    for (int k = 0; k < n; k++) text_bytes.push_back(w[8*k +: 8]);
  endtask

  task automatic build_random_text();
    int unsigned kind, idx, n, gsz, pat;
    bit          nz;
    text_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 30) begin
      // mark, maybe cut short, then a random tail
      idx = $urandom_range(NUM_MARKS - 1);
      for (int k = 0; k < sb.mark_len[idx]; k++)
        text_bytes.push_back(sb.mark_word[idx][8*k +: 8]);
      if (sb.mark_enc[idx] == ENC_UTF7) begin
        case ($urandom_range(4))
          0:       text_bytes.push_back(8'h38);
          1:       text_bytes.push_back(8'h39);
          2:       text_bytes.push_back(8'h2B);
          3:       text_bytes.push_back(8'h2F);
          default: text_bytes.push_back(rand_byte());
        endcase
      end
      if ($urandom_range(3) == 0) void'(text_bytes.pop_back());
      n = $urandom_range(6);
      repeat (n) text_bytes.push_back(rand_byte());
    end else if (kind < 55) begin
      // wide text: a fixed zero pattern per group, with a rare flip
      gsz = $urandom_range(1) ? 4 : 2;
      pat = $urandom_range((1 << gsz) - 1);
      n   = $urandom_range(4, 1);
      repeat (n) begin
        for (int k = 0; k < gsz; k++) begin
          nz = pat[k];
          if ($urandom_range(9) == 0) nz = !nz;
          text_bytes.push_back(nz ? 8'($urandom_range(255, 1)) : 8'h00);
        end
      end
      if ($urandom_range(5) == 0) text_bytes.push_back(rand_byte());
    end else if (kind < 85) begin
      n = $urandom_range(5, 1);
      repeat (n) begin
        case ($urandom_range(9))
          4: begin
            text_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
            text_bytes.push_back(cont_byte());
          end
          5: begin
            text_bytes.push_back(8'hE0);
            text_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
            text_bytes.push_back(cont_byte());
          end
          6: begin
            text_bytes.push_back(8'hED);
            text_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
            text_bytes.push_back(cont_byte());
          end
          7: begin
            text_bytes.push_back($urandom_range(1) ? 8'($urandom_range(8'hEC, 8'hE1))
                                                   : 8'($urandom_range(8'hEF, 8'hEE)));
            text_bytes.push_back(cont_byte());
            text_bytes.push_back(cont_byte());
          end
          8: begin
            case ($urandom_range(2))
              0: begin
                text_bytes.push_back(8'hF0);
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'h90)));
              end
              1: begin
                text_bytes.push_back(8'hF4);
                text_bytes.push_back(8'($urandom_range(8'h8F, 8'h80)));
              end
              default: begin
                text_bytes.push_back(8'($urandom_range(8'hF3, 8'hF1)));
                text_bytes.push_back(cont_byte());
              end
            endcase
            text_bytes.push_back(cont_byte());
            text_bytes.push_back(cont_byte());
          end
          9: begin
            // broken sequences
            case ($urandom_range(5))
              0: text_bytes.push_back(8'($urandom_range(8'hC1, 8'hC0)));
              1: text_bytes.push_back(8'($urandom_range(8'hFF, 8'hF5)));
              2: text_bytes.push_back(cont_byte());
              3: begin
                text_bytes.push_back(8'hE0);
                text_bytes.push_back(8'($urandom_range(8'h9F, 8'h80)));
              end
              4: begin
                text_bytes.push_back(8'hED);
                text_bytes.push_back(8'($urandom_range(8'hBF, 8'hA0)));
              end
              default: begin
                text_bytes.push_back(8'hC2);
                text_bytes.push_back(8'($urandom_range(8'h7F)));
              end
            endcase
          end
          default: text_bytes.push_back(8'($urandom_range(8'h7F)));
        endcase
      end
      // cut the last character short now and then
      if ($urandom_range(4) == 0 && text_bytes.size() > 1) void'(text_bytes.pop_back());
    end else begin
      n = $urandom_range(10, 1);
      repeat (n) text_bytes.push_back($urandom_range(1) ? rand_byte() : 8'($urandom_range(255)));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    sent_bytes   = 0;
    calm         = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_word(32'h00BFBBEF, 3);  // UTF-8 mark
    send_text();
    load_word(32'h0000FEFF, 4);  // UTF-16LE mark shadows UTF-32LE
    send_text();
    load_word(32'h38762F2B, 4);  // UTF-7 mark with a valid fourth byte
    send_text();
    load_word(32'h41762F2B, 4);  // UTF-7 prefix, wrong fourth byte
    send_text();
    load_word(32'h0000BBEF, 2);  // mark longer than the buffer
    send_text();
    load_word(32'h00000000, 1);  // single zero byte, group size one
    send_text();
    load_word(32'h000000C3, 1);  // cut-off last character
    send_text();
    load_word(32'h000000FF, 1);  // invalid UTF-8, falls back to Windows-1252
    send_text();
    load_word(32'h00000000, 4);  // all-zero group maps to nothing
    send_text();
    load_word(32'h00004100, 2);  // big-endian pair
    send_text();

    while (sent_bytes < RANDOM_BYTES) begin
      build_random_text();
      send_text();
    end
    in_valid <= 1'b0;
    // let the monitor note the final transfer first
    @(posedge clk);

    while (sb.verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("PASS text_encoding_detector_unit");
    else
      $display("FAIL text_encoding_detector_unit");
    $finish;
  end

endmodule
